[hw/rtl/page_extent_allocator_core_defines.svh]
// Assertion macros shared by the page extent allocator RTL.
// Included by files that carry concurrent assertions.
`ifndef PAGE_EXTENT_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_EXTENT_ALLOCATOR_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define PEA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked on every rising clock edge outside reset.
`define PEA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

[hw/rtl/pea_pkg.sv]
// Package for the page extent allocator: sizes, codes, payload types.
// No dependencies.
package pea_pkg;
  localparam int MaxExtents  = 16;
  localparam int PageShift   = 12;
  localparam int AddrBits    = 48;
  localparam int PageBits    = AddrBits - PageShift;
  localparam int IdxBits     = $clog2(MaxExtents);
  localparam int CntBits     = $clog2(MaxExtents + 1);
  localparam int CntFieldBits = 36;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [PageBits-1:0] pages_t;
  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [CntBits-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_ARG  = 2'd2,
    ST_FULL     = 2'd3
  } rsp_status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic {
    REG_BASE  = 1'b0,
    REG_BYTES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                    op;
    logic [CntFieldBits-1:0] page_count;
    logic [47:0]             release_address;
  } in_req_t;

  typedef struct packed {
    logic [47:0] granted_address;
    logic [1:0]  status;
  } out_rsp_t;

  typedef enum logic [3:0] {
    S_SEED, S_IDLE, S_RD, S_CHK, S_ALLOC_WR, S_REL_CHK, S_PREV_RD, S_PREV_CHK,
    S_SHIFT_DN_RD, S_SHIFT_DN_WR, S_SHIFT_UP_RD, S_SHIFT_UP_WR, S_DONE
  } state_t;

  // Memory command from the sequencer to the extent store.
  typedef struct packed {
    logic   wr;
    idx_t   wr_idx;
    addr_t  wr_base;
    pages_t wr_pages;
    idx_t   rd_idx;
  } mem_cmd_t;

  function automatic addr_t run_end(addr_t base, pages_t pages);
    return base + {pages, {PageShift{1'b0}}};
  endfunction
endpackage

[hw/rtl/pea_store.sv]
// Extent table storage: base and page count per entry, one write and one
// registered read per cycle. Depends on pea_pkg.
module pea_store
  import pea_pkg::*;
(
  input  logic     clk,
  input  mem_cmd_t cmd,
  output addr_t    rd_base,
  output pages_t   rd_pages
);
  addr_t  base_mem  [MaxExtents];
  pages_t pages_mem [MaxExtents];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      base_mem[cmd.wr_idx]  <= cmd.wr_base;
      pages_mem[cmd.wr_idx] <= cmd.wr_pages;
    end
    rd_base  <= base_mem[cmd.rd_idx];
    rd_pages <= pages_mem[cmd.rd_idx];
  end
endmodule

[hw/rtl/pea_seq.sv]
// Sequencer: walks the extent table entry by entry, reading then checking each, with a
// shared address adder, and shifts entries for inserts and removals. Depends on pea_pkg.
`include "page_extent_allocator_core_defines.svh"
module pea_seq
  import pea_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic     cfg_known,
  input  logic [47:0] cfg_data,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data,
  output mem_cmd_t cmd,
  input  addr_t    rd_base,
  input  pages_t   rd_pages
);
  state_t state_r, state_nxt;
  addr_t  reg_base_r, reg_base_nxt;
  addr_t  reg_bytes_r, reg_bytes_nxt;
  cnt_t   count_r, count_nxt;
  idx_t   idx_r, idx_nxt;      // scan position
  idx_t   tgt_r, tgt_nxt;      // shift target
  logic   op_r, op_nxt;
  pages_t n_r, n_nxt;
  addr_t  addr_r, addr_nxt;
  addr_t  cur_base_r, cur_base_nxt;
  pages_t cur_pages_r, cur_pages_nxt;
  addr_t  ins_base_r, ins_base_nxt;
  pages_t ins_pages_r, ins_pages_nxt;
  addr_t  mv_base_r, mv_base_nxt;
  pages_t mv_pages_r, mv_pages_nxt;
  logic   ovalid_r, ovalid_nxt;
  out_rsp_t odata_r, odata_nxt;

  // Shared arithmetic: one address adder, with its operands chosen per state.
  addr_t  sum_a, sum_b, sum_y;
  logic   [AddrBits:0] seed_sum;
  pages_t n_in;
  cnt_t   idx_ext;
  logic   cfg_take;

  assign sum_y = sum_a + sum_b;
  assign seed_sum = {1'b0, reg_base_r} + {1'b0, reg_bytes_r};
  assign n_in = PageBits'(in_data.page_count);
  assign idx_ext = CntBits'(idx_r);

  // Register writes are taken only between requests.
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_take  = cfg_valid && cfg_ready && cfg_known;

  assign in_stall  = !(state_r == S_IDLE) || cfg_valid || ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SEED;
      reg_base_r  <= '0;
      reg_bytes_r <= '0;
      count_r     <= '0;
      ovalid_r    <= 1'b0;
      mv_pages_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      reg_base_r  <= reg_base_nxt;
      reg_bytes_r <= reg_bytes_nxt;
      count_r     <= count_nxt;
      ovalid_r    <= ovalid_nxt;
      mv_pages_r  <= mv_pages_nxt;
    end
    idx_r <= idx_nxt; tgt_r <= tgt_nxt; op_r <= op_nxt; n_r <= n_nxt;
    addr_r <= addr_nxt; cur_base_r <= cur_base_nxt; cur_pages_r <= cur_pages_nxt;
    ins_base_r <= ins_base_nxt; ins_pages_r <= ins_pages_nxt;
    mv_base_r <= mv_base_nxt; odata_r <= odata_nxt;
  end

  always_comb begin
    state_nxt = state_r; reg_base_nxt = reg_base_r; reg_bytes_nxt = reg_bytes_r;
    count_nxt = count_r; idx_nxt = idx_r; tgt_nxt = tgt_r; op_nxt = op_r;
    n_nxt = n_r; addr_nxt = addr_r; cur_base_nxt = cur_base_r;
    cur_pages_nxt = cur_pages_r; ins_base_nxt = ins_base_r;
    ins_pages_nxt = ins_pages_r; mv_base_nxt = mv_base_r; mv_pages_nxt = mv_pages_r;
    ovalid_nxt = ovalid_r && out_stall; odata_nxt = odata_r;
    cmd = '0; cmd.rd_idx = idx_r;
    sum_a = cur_base_r; sum_b = {cur_pages_r, {PageShift{1'b0}}};

    if (cfg_take) begin
      if (cfg_index == REG_BASE) reg_base_nxt = cfg_data;
      else reg_bytes_nxt = cfg_data;
    end

    case (state_r)
      S_SEED: begin
        cmd.wr = 1'b1; cmd.wr_idx = '0; cmd.wr_base = reg_base_r;
        cmd.wr_pages = PageBits'(reg_bytes_r >> PageShift);
        count_nxt = seed_sum[AddrBits] ? '0 : cnt_t'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_take) begin
          state_nxt = S_SEED;
        end else if (in_valid && !ovalid_r) begin
          op_nxt = in_data.op; n_nxt = n_in; addr_nxt = in_data.release_address;
          idx_nxt = '0; cmd.rd_idx = '0;
          if (in_data.op == OP_RELEASE && (in_data.release_address == '0 ||
              in_data.release_address[PageShift-1:0] != '0 || n_in == '0)) begin
            odata_nxt = '{granted_address: '0, status: ST_BAD_ARG};
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            if (in_data.op == OP_ALLOC) begin
              odata_nxt = '{granted_address: '0, status: ST_NO_SPACE};
              state_nxt = S_DONE;
            end else begin
              cmd.wr = 1'b1; cmd.wr_idx = '0;
              cmd.wr_base = in_data.release_address; cmd.wr_pages = n_in;
              count_nxt = cnt_t'(1);
              odata_nxt = '{granted_address: '0, status: ST_OK};
              state_nxt = S_DONE;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_CHK;   // read data lands
      S_CHK: begin
        cur_base_nxt = rd_base; cur_pages_nxt = rd_pages;
        if (op_r == OP_ALLOC) begin
          if (rd_pages >= n_r) begin
            odata_nxt = '{granted_address: rd_base, status: ST_OK};
            cur_pages_nxt = rd_pages - n_r;
            state_nxt = S_ALLOC_WR;
          end else if (idx_ext + 1'b1 >= count_r) begin
            odata_nxt = '{granted_address: '0, status: ST_NO_SPACE};
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1; cmd.rd_idx = idx_r + 1'b1; state_nxt = S_RD;
          end
        end else begin
          if (addr_r < rd_base) begin
            state_nxt = S_REL_CHK;
          end else if (idx_ext + 1'b1 >= count_r) begin
            idx_nxt = idx_r; tgt_nxt = idx_r; // append at count
            state_nxt = S_REL_CHK;
          end else begin
            idx_nxt = idx_r + 1'b1; cmd.rd_idx = idx_r + 1'b1; state_nxt = S_RD;
          end
        end
      end
      S_ALLOC_WR: begin
        sum_a = cur_base_r; sum_b = {n_r, {PageShift{1'b0}}};
        if (cur_pages_r == '0) begin
          // Extent emptied: close the gap from idx upward.
          count_nxt = count_r - 1'b1;
          if (idx_ext + 1'b1 < count_r) begin
            cmd.rd_idx = idx_r + 1'b1; state_nxt = S_SHIFT_DN_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.wr = 1'b1; cmd.wr_idx = idx_r; cmd.wr_base = sum_y;
          cmd.wr_pages = cur_pages_r;
          state_nxt = S_DONE;
        end
      end
      S_REL_CHK: begin
        // Here cur holds entry idx; decide merge, insert, append or full.
        sum_a = addr_r; sum_b = {n_r, {PageShift{1'b0}}};
        odata_nxt = '{granted_address: '0, status: ST_OK};
        if (addr_r < cur_base_r && sum_y == cur_base_r) begin
          cur_base_nxt = addr_r; cur_pages_nxt = cur_pages_r + n_r;
          cmd.wr = 1'b1; cmd.wr_idx = idx_r; cmd.wr_base = addr_r;
          cmd.wr_pages = cur_pages_r + n_r;
          if (idx_r != '0) begin
            cmd.rd_idx = idx_r - 1'b1; state_nxt = S_PREV_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (count_r >= cnt_t'(MaxExtents)) begin
          odata_nxt = '{granted_address: '0, status: ST_FULL};
          state_nxt = S_DONE;
        end else begin
          ins_base_nxt = addr_r; ins_pages_nxt = n_r;
          // Insert position: idx if below, else count (append).
          if (!(addr_r < cur_base_r)) idx_nxt = idx_r + 1'b1;
          tgt_nxt = IdxBits'(count_r);
          count_nxt = count_r + 1'b1;
          cmd.rd_idx = IdxBits'(count_r) - 1'b1;
          state_nxt = S_SHIFT_UP_RD;
          if (!(addr_r < cur_base_r)) begin
            cmd.wr = 1'b1; cmd.wr_idx = IdxBits'(count_r); cmd.wr_base = addr_r;
            cmd.wr_pages = n_r; state_nxt = S_DONE;
          end
        end
      end
      S_PREV_RD: begin
        cmd.rd_idx = idx_r - 1'b1;
        state_nxt = S_PREV_CHK;
      end
      S_PREV_CHK: begin
        sum_a = rd_base; sum_b = {rd_pages, {PageShift{1'b0}}};
        if (sum_y == cur_base_r) begin
          cmd.wr = 1'b1; cmd.wr_idx = idx_r - 1'b1; cmd.wr_base = rd_base;
          cmd.wr_pages = cur_pages_r + rd_pages;
          count_nxt = count_r - 1'b1;
          if (idx_ext + 1'b1 < count_r) begin
            cmd.rd_idx = idx_r + 1'b1; state_nxt = S_SHIFT_DN_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_DN_RD: begin
        cmd.rd_idx = idx_r + 1'b1;
        state_nxt = S_SHIFT_DN_WR;
      end
      S_SHIFT_DN_WR: begin
        // Move entry idx+1 down to idx.
        cmd.wr = 1'b1; cmd.wr_idx = idx_r; cmd.wr_base = rd_base; cmd.wr_pages = rd_pages;
        idx_nxt = idx_r + 1'b1;
        if (idx_ext + 1'b1 < CntBits'(count_r)) begin
          cmd.rd_idx = idx_r + 2'd2; state_nxt = S_SHIFT_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_UP_RD: begin
        cmd.rd_idx = tgt_r - 1'b1;
        state_nxt = S_SHIFT_UP_WR;
      end
      S_SHIFT_UP_WR: begin
        // Move entry tgt-1 up to tgt, then drop the new run in at idx.
        cmd.wr = 1'b1; cmd.wr_idx = tgt_r; cmd.wr_base = rd_base; cmd.wr_pages = rd_pages;
        tgt_nxt = tgt_r - 1'b1;
        if (tgt_r - 1'b1 == idx_r) begin
          mv_base_nxt = ins_base_r; mv_pages_nxt = ins_pages_r;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_idx = tgt_r - 2'd2; state_nxt = S_SHIFT_UP_RD;
        end
      end
      S_DONE: begin
        if (op_r == OP_RELEASE && tgt_r == idx_r && odata_r.status == ST_OK &&
            mv_pages_r != '0) begin
          cmd.wr = 1'b1; cmd.wr_idx = idx_r; cmd.wr_base = mv_base_r;
          cmd.wr_pages = mv_pages_r;
        end
        mv_pages_nxt = '0;
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `PEA_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= cnt_t'(MaxExtents), "count over depth")
  `PEA_ASSERT_IMP(a_busy_stall, clk, rst_n, state_r != S_IDLE, in_stall, "accepted while busy")
  `PEA_ASSERT_IMP(a_out_hold, clk, rst_n, ovalid_r && out_stall, ##1 ovalid_r, "result lost")
endmodule

[hw/rtl/page_extent_allocator_core.sv]
// Top level of the page extent allocator: sequencer plus extent store.
// Depends on pea_pkg, pea_seq and pea_store.
// A request is accepted, then each table entry scanned is read and checked, the
// outcome is decided, a release that also merges with the entry below reads and
// checks that entry, each entry moved on an insert or removal is read and written,
// and the result is posted; scan and moves together cover the table once. The
// one-read, one-write extent store sets this order of work. Config writes are taken
// only while idle and reseed the table in the following cycle. One result per
// request; the next request is taken once the result has been accepted.
module page_extent_allocator_core
  import pea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_rsp_t    out_data
);
  mem_cmd_t cmd;
  addr_t    rd_base;
  pages_t   rd_pages;

  pea_seq u_seq (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index(cfg_index[0]), .cfg_known(1'b1),
    .cfg_data, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cmd, .rd_base, .rd_pages
  );

  pea_store u_store (.clk, .cmd, .rd_base, .rd_pages);
endmodule

[dv/page_extent_allocator_core_tb.sv]
// Self-checking testbench for page_extent_allocator_core.
// Holds its own first-fit extent table to predict every response; depends on pea_pkg and page_extent_allocator_core.
`timescale 1ns / 100ps

module page_extent_allocator_core_tb;
  import pea_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 120;

  typedef struct {
    addr_t  addr;
    pages_t pages;
  } run_t;

  class extent_scoreboard;
    addr_t    ext_base[MaxExtents];
    pages_t   ext_pages[MaxExtents];
    int       ext_count;
    addr_t    reg_base;
    addr_t    reg_bytes;
    out_rsp_t expected_q[$];
    int       errors;
    int       checked;

    function new();
      reg_base  = '0;
      reg_bytes = '0;
      errors    = 0;
      checked   = 0;
      reseed();
    endfunction

    function void reseed();
      logic [AddrBits:0] sum;
      sum = {1'b0, reg_base} + {1'b0, reg_bytes};
      if (sum[AddrBits]) begin
        ext_count = 0;
      end else begin
        ext_base[0]  = reg_base;
        ext_pages[0] = reg_bytes[AddrBits-1:PageShift];
        ext_count    = 1;
      end
    endfunction

    function void write_reg(reg_idx_t idx, addr_t value);
      if (idx == REG_BASE) reg_base = value;
      else reg_bytes = value;
      reseed();
    endfunction

    function addr_t end_of(addr_t b, pages_t p);
      return b + {p, {PageShift{1'b0}}};
    endfunction

    function void drop(int i);
      for (int k = i; k + 1 < ext_count; k++) begin
        ext_base[k]  = ext_base[k+1];
        ext_pages[k] = ext_pages[k+1];
      end
      ext_count--;
    endfunction

    function rsp_status_t insert(int i, addr_t b, pages_t p);
      if (ext_count >= MaxExtents) return ST_FULL;
      for (int k = ext_count; k > i; k--) begin
        ext_base[k]  = ext_base[k-1];
        ext_pages[k] = ext_pages[k-1];
      end
      ext_base[i]  = b;
      ext_pages[i] = p;
      ext_count++;
      return ST_OK;
    endfunction

    function rsp_status_t release_run(addr_t a, pages_t n);
      if (a == '0 || a[PageShift-1:0] != '0 || n == '0) return ST_BAD_ARG;
      if (ext_count == 0) return insert(0, a, n);
      for (int i = 0; i < ext_count; i++) begin
        if (a < ext_base[i]) begin
          if (end_of(a, n) != ext_base[i]) return insert(i, a, n);
          ext_base[i]  = a;
          ext_pages[i] = ext_pages[i] + n;
          // The grown extent may now close the gap to its lower neighbor.
          if (i > 0 && end_of(ext_base[i-1], ext_pages[i-1]) == ext_base[i]) begin
            ext_base[i]  = ext_base[i-1];
            ext_pages[i] = ext_pages[i] + ext_pages[i-1];
            drop(i - 1);
          end
          return ST_OK;
        end
      end
      return insert(ext_count, a, n);
    endfunction

    function out_rsp_t note_request(in_req_t r);
      out_rsp_t rsp;
      pages_t   n;
      n = r.page_count;
      rsp.granted_address = '0;
      if (r.op == OP_RELEASE) begin
        rsp.status = release_run(r.release_address, n);
      end else begin
        rsp.status = ST_NO_SPACE;
        for (int i = 0; i < ext_count; i++) begin
          if (ext_pages[i] >= n) begin
            rsp.granted_address = ext_base[i];
            rsp.status = ST_OK;
            ext_pages[i] = ext_pages[i] - n;
            ext_base[i]  = end_of(ext_base[i], n);
            if (ext_pages[i] == '0) drop(i);
            break;
          end
        end
      end
      expected_q.push_back(rsp);
      return rsp;
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected response: granted_address %h status %0d",
               got.granted_address, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.granted_address !== want.granted_address) begin
        $error("granted_address: expected %h, actual %h",
               want.granted_address, got.granted_address);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_index = 1'b0;
  addr_t    cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  extent_scoreboard sb = new();
  run_t live_q[$];
  bit   quiet = 1'b0;
  int   cycles = 0;
  int   sent = 0;

  page_extent_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** page_extent_allocator_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_response(out_data);
  end

  // Receiver back-pressure in bursts, switched off near the end of the run.
  initial begin
    int len;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic addr_t rand_addr();
    return AddrBits'({$urandom(), $urandom()});
  endfunction

  function automatic pages_t rand_pages();
    return PageBits'({$urandom(), $urandom()});
  endfunction

  task automatic write_cfg(reg_idx_t idx, addr_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_req(logic op, pages_t n, addr_t a);
    in_req_t  r;
    out_rsp_t e;
    int       gap;
    r.op = op;
    r.page_count = n;
    r.release_address = a;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    e = sb.note_request(r);
    sent++;
    if (op == OP_ALLOC && e.status == ST_OK && n != '0)
      live_q.push_back('{e.granted_address, n});
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reconfigure(addr_t b, addr_t bytes);
    drain();
    write_cfg(REG_BASE, b);
    write_cfg(REG_BYTES, bytes);
    live_q.delete();
  endtask

  // Mostly allocations and releases of runs handed out earlier, plus some noise.
  task automatic random_request();
    int     pick;
    int     k;
    run_t   r;
    pages_t part;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      case ($urandom_range(0, 9))
        0:       send_req(OP_ALLOC, rand_pages(), '0);
        1:       send_req(OP_ALLOC, PageBits'($urandom_range(0, 64)), rand_addr());
        default: send_req(OP_ALLOC, PageBits'($urandom_range(1, 8)), '0);
      endcase
    end else if (pick < 88 && live_q.size() != 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      r = live_q[k];
      live_q.delete(k);
      if (r.pages > 1 && $urandom_range(0, 3) == 0) begin
        part = PageBits'($urandom_range(1, 7));
        if (part >= r.pages) part = r.pages - 1;
        live_q.push_back('{r.addr + {part, {PageShift{1'b0}}}, r.pages - part});
        r.pages = part;
      end
      send_req(OP_RELEASE, r.pages, r.addr);
    end else begin
      case ($urandom_range(0, 4))
        0: send_req(OP_RELEASE, rand_pages(), rand_addr());
        1: send_req(OP_RELEASE, PageBits'($urandom_range(1, 4)), '0);
        2: send_req(OP_RELEASE, 0, (rand_addr() >> PageShift) << PageShift);
        3: send_req(OP_RELEASE, PageBits'($urandom_range(1, 4)), rand_addr() | 48'h1);
        default: send_req(OP_RELEASE, PageBits'($urandom_range(1, 16)),
                          (rand_addr() >> PageShift) << PageShift);
      endcase
    end
  endtask

  initial begin
    addr_t cfg_bases[6];
    addr_t cfg_sizes[6];
    cfg_bases = '{48'h0000_0040_0000, 48'h0, 48'h8000_0000_0000,
                  48'hFFFF_FFFF_F000, 48'h0000_0000_1000, 48'h0000_1000_0000};
    cfg_sizes = '{48'h0000_0004_0000, 48'hFFFF_FFFF_FFFF, 48'h0000_0040_0000,
                  48'h0000_0000_1000, 48'h0, 48'h0000_0002_0000};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the table holds one empty extent at address zero.
    send_req(OP_ALLOC, 0, '0);
    send_req(OP_ALLOC, 1, '0);
    send_req(OP_RELEASE, 1, '0);
    send_req(OP_RELEASE, 1, 48'h0000_0000_5800);
    send_req(OP_RELEASE, 0, 48'h0000_0000_5000);
    send_req(OP_RELEASE, 2, 48'h0000_0000_5000);
    send_req(OP_ALLOC, 2, '0);

    reconfigure(48'h0000_0010_0000, 48'h0000_0001_0000);
    send_req(OP_ALLOC, 4, '0);
    send_req(OP_ALLOC, 4, '0);
    send_req(OP_RELEASE, 4, 48'h0000_0010_0000);
    send_req(OP_RELEASE, 4, 48'h0000_0010_4000);
    send_req(OP_ALLOC, 36'hF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_req(OP_ALLOC, 16, '0);
    send_req(OP_RELEASE, 36'hF_FFFF_FFFF, 48'hFFFF_FFFF_F000);

    // Region overflows, so the table starts empty; ascending adjacent
    // releases append without merging until the table is full.
    reconfigure(48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF);
    for (int k = 1; k <= MaxExtents + 1; k++)
      send_req(OP_RELEASE, 1, addr_t'(k) << PageShift);
    send_req(OP_ALLOC, 1, '0);

    for (int p = 0; p < 6; p++) begin
      reconfigure(cfg_bases[p], cfg_sizes[p]);
      if (p == 5) quiet = 1'b1;
      repeat (258) random_request();
    end

    drain();
    $display("Sent %0d requests over 8 region settings; %0d responses checked.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** page_extent_allocator_core: PASSED **");
    end else begin
      $display("** page_extent_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
